@@ rtl/core/piecewise_linear_curve_table_macros.svh @@
// Assertion helpers for the curve table checker.
`ifndef PIECEWISE_LINEAR_CURVE_TABLE_MACROS_SVH
`define PIECEWISE_LINEAR_CURVE_TABLE_MACROS_SVH

// Same-cycle implication.
`define PLCT_ASSERT_IMP(name, trig, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

// Next-cycle implication.
`define PLCT_ASSERT_NEXT(name, trig, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

@@ rtl/core/plct_pkg.sv @@
`default_nettype none

package plct_pkg;

  localparam int unsigned DEF_MAX_KNOTS = 64;
  localparam int unsigned VAL_W = 17;

  localparam logic [VAL_W-1:0] Q_ONE          = 17'h10000;
  localparam logic [VAL_W-1:0] HIT_RADIUS_RST = 17'd1096;

  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_DELETE = 3'd1;
  localparam logic [2:0] REQ_MOVE   = 3'd2;
  localparam logic [2:0] REQ_FIND   = 3'd3;
  localparam logic [2:0] REQ_MAP    = 3'd4;
  localparam logic [2:0] REQ_RESET  = 3'd5;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_RANGE     = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [2:0] STAT_ENDPOINT  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_FIN,
    S_OUT
  } state_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INIT,
    CELL_SHIFT_UP,
    CELL_SHIFT_DN,
    CELL_LOAD,
    CELL_LOAD_Y,
    CELL_MOVE
  } cell_op_e;

  typedef struct packed {
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] y;
    logic [VAL_W-1:0] radius;
  } bus_t;

  typedef struct packed {
    logic lt;
    logic hit;
  } cell_flag_t;

  function automatic logic [VAL_W-1:0] clamp_one(input logic [VAL_W-1:0] v);
    return (v > Q_ONE) ? Q_ONE : v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/plct_req_if.sv @@
`default_nettype none

interface plct_req_if #(
  parameter int unsigned IDX_W = $clog2(plct_pkg::DEF_MAX_KNOTS)
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   req_type;
  logic [plct_pkg::VAL_W-1:0]   pos_x;
  logic [plct_pkg::VAL_W-1:0]   pos_y;
  logic [IDX_W-1:0]             knot_index;

  modport source (output valid, req_type, pos_x, pos_y, knot_index, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, knot_index, output ready);
endinterface

`default_nettype wire

@@ rtl/core/plct_rsp_if.sv @@
`default_nettype none

interface plct_rsp_if #(
  parameter int unsigned IDX_W = $clog2(plct_pkg::DEF_MAX_KNOTS),
  parameter int unsigned CNT_W = $clog2(plct_pkg::DEF_MAX_KNOTS + 1)
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   status;
  logic [IDX_W-1:0]             result_index;
  logic [plct_pkg::VAL_W-1:0]   mapped_value;
  logic [CNT_W-1:0]             knot_total;

  modport source (output valid, status, result_index, mapped_value, knot_total, input ready);
  modport sink   (input valid, status, result_index, mapped_value, knot_total, output ready);
endinterface

`default_nettype wire

@@ rtl/core/plct_cfg_if.sv @@
`default_nettype none

interface plct_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [plct_pkg::VAL_W-1:0]   hit_radius;

  modport source (output valid, hit_radius, input ready);
  modport sink   (input valid, hit_radius, output ready);
endinterface

`default_nettype wire

@@ rtl/core/plct_cell.sv @@
`default_nettype none

module plct_cell #(
  parameter logic [plct_pkg::VAL_W-1:0] INIT_X = '0,
  parameter logic [plct_pkg::VAL_W-1:0] INIT_Y = '0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  plct_pkg::cell_op_e         op_i,
  input  plct_pkg::bus_t             bus_i,
  input  logic [plct_pkg::VAL_W-1:0] left_x_i,
  input  logic [plct_pkg::VAL_W-1:0] left_y_i,
  input  logic [plct_pkg::VAL_W-1:0] right_x_i,
  input  logic [plct_pkg::VAL_W-1:0] right_y_i,
  output logic [plct_pkg::VAL_W-1:0] x_o,
  output logic [plct_pkg::VAL_W-1:0] y_o,
  output plct_pkg::cell_flag_t       flag_o
);

  logic [plct_pkg::VAL_W-1:0] x_q, x_d, y_q, y_d;
  logic [plct_pkg::VAL_W-1:0] dx, dy;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    case (op_i)
      plct_pkg::CELL_HOLD: begin
      end
      plct_pkg::CELL_INIT: begin
        x_d = INIT_X;
        y_d = INIT_Y;
      end
      plct_pkg::CELL_SHIFT_UP: begin
        x_d = left_x_i;
        y_d = left_y_i;
      end
      plct_pkg::CELL_SHIFT_DN: begin
        x_d = right_x_i;
        y_d = right_y_i;
      end
      plct_pkg::CELL_LOAD: begin
        x_d = bus_i.x;
        y_d = bus_i.y;
      end
      plct_pkg::CELL_LOAD_Y: begin
        y_d = bus_i.y;
      end
      plct_pkg::CELL_MOVE: begin
        if (bus_i.x < left_x_i) begin
          x_d = left_x_i;
        end else if (bus_i.x > right_x_i) begin
          x_d = right_x_i;
        end else begin
          x_d = bus_i.x;
        end
        y_d = bus_i.y;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= INIT_X;
      y_q <= INIT_Y;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  always_comb begin
    dx = (bus_i.x >= x_q) ? (bus_i.x - x_q) : (x_q - bus_i.x);
    dy = (bus_i.y >= y_q) ? (bus_i.y - y_q) : (y_q - bus_i.y);
    flag_o.lt  = x_q < bus_i.x;
    flag_o.hit = (dx <= bus_i.radius) && (dy <= bus_i.radius);
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

`default_nettype wire

@@ rtl/core/plct_div.sv @@
`default_nettype none

module plct_div #(
  parameter int unsigned NUM_W = 34,
  parameter int unsigned DEN_W = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   sh, diff;
  logic             ge, last;

  always_comb begin
    sh   = {rem_q, quo_q[NUM_W-1]};
    diff = sh - {1'b0, den_q};
    ge   = sh >= {1'b0, den_q};
    last = cnt_q == CW'(NUM_W - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

@@ rtl/core/piecewise_linear_curve_table.sv @@
// Piecewise-linear curve table: knots (x, y) in Q16, sorted by x, from (0,0) to (1,1).
// Channels: req (request in: type, pos_x, pos_y, knot_index), rsp (one result per
// request: status, result_index, mapped_value, knot_total), cfg (hit_radius write).
// All use valid/ready; a transfer happens when both are high on a clock edge.
// One request is processed at a time. Knots live in a row of cells that compare
// against the broadcast request in parallel and shift into their neighbors for
// insert and delete; the first matching knot is located by shifting the match
// vector one cell per cycle.
// After accept, insert, find and map scan the match vector up to the first match
// (at most MAX_KNOTS cells); map then runs a 34-step restoring divider unless the
// segment is vertical. Delete, move and reset skip the scan; an out-of-range
// insert or map and a map of 0 skip it too and go straight to the output.
// req.ready is high only while idle: the next request can be taken in the cycle
// after the previous result is loaded into the output register, so a stalled rsp
// delays the next request only while a result still sits there.
// Reset (rst_ni low) restores the two endpoint knots and hit_radius = 1096.
`default_nettype none

module piecewise_linear_curve_table #(
  parameter  int unsigned MAX_KNOTS = plct_pkg::DEF_MAX_KNOTS,
  localparam int unsigned IDX_W     = $clog2(MAX_KNOTS),
  localparam int unsigned CNT_W     = $clog2(MAX_KNOTS + 1)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  plct_req_if.sink   req,
  plct_rsp_if.source rsp,
  plct_cfg_if.sink   cfg
);

  localparam int unsigned VW = plct_pkg::VAL_W;
  localparam int unsigned PW = 2 * VW;

  plct_pkg::state_e state_q, state_d;

  logic [2:0]           req_q;
  logic [VW-1:0]        px_q, py_q, radius_q;
  logic [IDX_W-1:0]     ki_q, idx_q, idx_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [MAX_KNOTS-1:0] vec_q, vec_d;
  logic                 found_q, found_d;
  logic [2:0]           stat_q, stat_d;
  logic [IDX_W-1:0]     ridx_q, ridx_d;
  logic [VW-1:0]        map_q, map_d;
  logic [VW-1:0]        y0_q, y0_d, dx_q, dx_d, ady_q, ady_d, ddx_q, ddx_d;
  logic                 neg_q, neg_d;

  logic                 rsp_vld_q, rsp_vld_d, out_load;
  logic [2:0]           o_stat_q;
  logic [IDX_W-1:0]     o_ridx_q;
  logic [VW-1:0]        o_map_q;
  logic [CNT_W-1:0]     o_cnt_q;

  logic [VW-1:0]        cx [MAX_KNOTS];
  logic [VW-1:0]        cy [MAX_KNOTS];
  plct_pkg::cell_flag_t cf [MAX_KNOTS];
  plct_pkg::cell_op_e   cop [MAX_KNOTS];
  plct_pkg::bus_t       bus;

  logic [MAX_KNOTS-1:0] valid, lt, hit;
  logic [VW-1:0]        sel_x, sel_y, prv_x, prv_y;
  logic [IDX_W-1:0]     last_idx, prv_idx;
  logic                 ki_ok, interior, full, eq_x, accept, px_bad;

  logic                 div_start, div_done;
  logic [PW-1:0]        prod, quo;
  logic signed [PW+1:0] y0_ext, q_ext, sum;
  logic [VW-1:0]        fin_val;

  // knot cells
  for (genvar g = 0; g < MAX_KNOTS; g++) begin : g_cell
    localparam logic [VW-1:0] IV = (g == 1) ? plct_pkg::Q_ONE : '0;
    plct_cell #(
      .INIT_X (IV),
      .INIT_Y (IV)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (cop[g]),
      .bus_i     (bus),
      .left_x_i  (cx[(g == 0) ? 0 : g - 1]),
      .left_y_i  (cy[(g == 0) ? 0 : g - 1]),
      .right_x_i (cx[(g == MAX_KNOTS - 1) ? g : g + 1]),
      .right_y_i (cy[(g == MAX_KNOTS - 1) ? g : g + 1]),
      .x_o       (cx[g]),
      .y_o       (cy[g]),
      .flag_o    (cf[g])
    );
  end

  plct_div #(
    .NUM_W (PW),
    .DEN_W (VW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod),
    .den_i   (ddx_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign accept    = req.valid && req.ready;
  assign req.ready = state_q == plct_pkg::S_IDLE;
  assign cfg.ready = 1'b1;

  always_comb begin
    bus.x      = (req_q == plct_pkg::REQ_MOVE) ? plct_pkg::clamp_one(px_q) : px_q;
    bus.y      = (req_q == plct_pkg::REQ_FIND) ? py_q : plct_pkg::clamp_one(py_q);
    bus.radius = radius_q;
  end

  always_comb begin
    last_idx = IDX_W'(count_q - 1'b1);
    prv_idx  = idx_q - 1'b1;
    sel_x = '0;
    sel_y = '0;
    prv_x = '0;
    prv_y = '0;
    for (int j = 0; j < MAX_KNOTS; j++) begin
      valid[j] = CNT_W'(j) < count_q;
      lt[j]    = cf[j].lt;
      hit[j]   = cf[j].hit;
      sel_x = sel_x | (cx[j] & {VW{idx_q == IDX_W'(j)}});
      sel_y = sel_y | (cy[j] & {VW{idx_q == IDX_W'(j)}});
      prv_x = prv_x | (cx[j] & {VW{prv_idx == IDX_W'(j)}});
      prv_y = prv_y | (cy[j] & {VW{prv_idx == IDX_W'(j)}});
    end
    ki_ok    = CNT_W'(ki_q) < count_q;
    interior = (ki_q != '0) && (ki_q != last_idx);
    full     = count_q == CNT_W'(MAX_KNOTS);
    eq_x     = sel_x == px_q;
    px_bad   = px_q > plct_pkg::Q_ONE;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      plct_pkg::S_IDLE: begin
        if (accept) begin
          state_d = plct_pkg::S_EVAL;
        end
      end
      plct_pkg::S_EVAL: begin
        case (req_q)
          plct_pkg::REQ_INSERT: state_d = px_bad ? plct_pkg::S_OUT : plct_pkg::S_SCAN;
          plct_pkg::REQ_MAP: begin
            if (px_bad || px_q == '0) begin
              state_d = plct_pkg::S_OUT;
            end else begin
              state_d = plct_pkg::S_SCAN;
            end
          end
          plct_pkg::REQ_FIND: state_d = plct_pkg::S_SCAN;
          default:            state_d = plct_pkg::S_EXEC;
        endcase
      end
      plct_pkg::S_SCAN: begin
        if (vec_q[0] || idx_q == last_idx) begin
          state_d = plct_pkg::S_EXEC;
        end
      end
      plct_pkg::S_EXEC: begin
        if (req_q == plct_pkg::REQ_MAP && found_q && sel_x != prv_x) begin
          state_d = plct_pkg::S_MUL;
        end else begin
          state_d = plct_pkg::S_OUT;
        end
      end
      plct_pkg::S_MUL: state_d = plct_pkg::S_DIV;
      plct_pkg::S_DIV: begin
        if (div_done) begin
          state_d = plct_pkg::S_FIN;
        end
      end
      plct_pkg::S_FIN: state_d = plct_pkg::S_OUT;
      plct_pkg::S_OUT: begin
        if (!rsp_vld_q || rsp.ready) begin
          state_d = plct_pkg::S_IDLE;
        end
      end
      default: state_d = plct_pkg::S_IDLE;
    endcase
  end

  // cell control, divider start, output load
  always_comb begin
    for (int j = 0; j < MAX_KNOTS; j++) begin
      cop[j] = plct_pkg::CELL_HOLD;
      if (state_q == plct_pkg::S_EXEC) begin
        case (req_q)
          plct_pkg::REQ_INSERT: begin
            if (found_q && eq_x) begin
              if (idx_q == IDX_W'(j)) begin
                cop[j] = plct_pkg::CELL_LOAD_Y;
              end
            end else if (found_q && !full) begin
              if (idx_q == IDX_W'(j)) begin
                cop[j] = plct_pkg::CELL_LOAD;
              end else if (IDX_W'(j) > idx_q && CNT_W'(j) <= count_q) begin
                cop[j] = plct_pkg::CELL_SHIFT_UP;
              end
            end
          end
          plct_pkg::REQ_DELETE: begin
            if (ki_ok && interior && CNT_W'(j) >= CNT_W'(ki_q) &&
                CNT_W'(j) < count_q - 1'b1) begin
              cop[j] = plct_pkg::CELL_SHIFT_DN;
            end
          end
          plct_pkg::REQ_MOVE: begin
            if (ki_ok && ki_q == IDX_W'(j)) begin
              cop[j] = interior ? plct_pkg::CELL_MOVE : plct_pkg::CELL_LOAD_Y;
            end
          end
          plct_pkg::REQ_RESET: begin
            if (j < 2) begin
              cop[j] = plct_pkg::CELL_INIT;
            end
          end
          default: begin
          end
        endcase
      end
    end
    div_start = state_q == plct_pkg::S_MUL;
    out_load  = (state_q == plct_pkg::S_OUT) && (!rsp_vld_q || rsp.ready);
  end

  // datapath
  always_comb begin
    idx_d   = idx_q;
    vec_d   = vec_q;
    found_d = found_q;
    stat_d  = stat_q;
    ridx_d  = ridx_q;
    map_d   = map_q;
    count_d = count_q;
    y0_d    = y0_q;
    dx_d    = dx_q;
    ady_d   = ady_q;
    ddx_d   = ddx_q;
    neg_d   = neg_q;
    case (state_q)
      plct_pkg::S_IDLE: begin
        stat_d  = plct_pkg::STAT_OK;
        ridx_d  = '0;
        map_d   = '0;
        found_d = 1'b0;
      end
      plct_pkg::S_EVAL: begin
        idx_d = '0;
        case (req_q)
          plct_pkg::REQ_INSERT: begin
            vec_d = valid & ~lt;
            if (px_bad) begin
              stat_d = plct_pkg::STAT_RANGE;
            end
          end
          plct_pkg::REQ_MAP: begin
            vec_d = valid & ~lt & ~MAX_KNOTS'(1);
            if (px_bad) begin
              stat_d = plct_pkg::STAT_RANGE;
            end else if (px_q == '0) begin
              map_d = cy[0];
            end
          end
          plct_pkg::REQ_FIND: vec_d = valid & hit;
          default: begin
          end
        endcase
      end
      plct_pkg::S_SCAN: begin
        if (vec_q[0]) begin
          found_d = 1'b1;
        end else if (idx_q != last_idx) begin
          vec_d = vec_q >> 1;
          idx_d = idx_q + 1'b1;
        end
      end
      plct_pkg::S_EXEC: begin
        case (req_q)
          plct_pkg::REQ_INSERT: begin
            if (!found_q) begin
              stat_d = plct_pkg::STAT_RANGE;
            end else if (eq_x) begin
              ridx_d = idx_q;
            end else if (full) begin
              stat_d = plct_pkg::STAT_FULL;
            end else begin
              ridx_d  = idx_q;
              count_d = count_q + 1'b1;
            end
          end
          plct_pkg::REQ_DELETE: begin
            if (!ki_ok) begin
              stat_d = plct_pkg::STAT_RANGE;
            end else if (!interior) begin
              stat_d = plct_pkg::STAT_ENDPOINT;
            end else begin
              ridx_d  = ki_q;
              count_d = count_q - 1'b1;
            end
          end
          plct_pkg::REQ_MOVE: begin
            if (!ki_ok) begin
              stat_d = plct_pkg::STAT_RANGE;
            end else begin
              ridx_d = ki_q;
            end
          end
          plct_pkg::REQ_FIND: begin
            if (found_q) begin
              ridx_d = idx_q;
            end else begin
              stat_d = plct_pkg::STAT_NOT_FOUND;
            end
          end
          plct_pkg::REQ_MAP: begin
            if (!found_q) begin
              stat_d = plct_pkg::STAT_RANGE;
            end else if (sel_x == prv_x) begin
              map_d = sel_y;
            end
            y0_d  = prv_y;
            dx_d  = px_q - prv_x;
            ddx_d = sel_x - prv_x;
            neg_d = sel_y < prv_y;
            ady_d = (sel_y < prv_y) ? (prv_y - sel_y) : (sel_y - prv_y);
          end
          plct_pkg::REQ_RESET: count_d = CNT_W'(2);
          default:             stat_d  = plct_pkg::STAT_RANGE;
        endcase
      end
      plct_pkg::S_FIN: map_d = fin_val;
      default: begin
      end
    endcase
  end

  assign prod = dx_q * ady_q;

  always_comb begin
    y0_ext = $signed({{(PW + 2 - VW){1'b0}}, y0_q});
    q_ext  = $signed({2'b00, quo});
    sum    = neg_q ? (y0_ext - q_ext) : (y0_ext + q_ext);
    if (sum < 0) begin
      fin_val = '0;
    end else if (sum > $signed({{(PW + 2 - VW){1'b0}}, plct_pkg::Q_ONE})) begin
      fin_val = plct_pkg::Q_ONE;
    end else begin
      fin_val = sum[VW-1:0];
    end
  end

  always_comb begin
    rsp_vld_d = rsp_vld_q;
    if (out_load) begin
      rsp_vld_d = 1'b1;
    end else if (rsp.ready) begin
      rsp_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= plct_pkg::S_IDLE;
      count_q   <= CNT_W'(2);
      radius_q  <= plct_pkg::HIT_RADIUS_RST;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rsp_vld_q <= rsp_vld_d;
      if (cfg.valid && cfg.ready) begin
        radius_q <= cfg.hit_radius;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req.req_type;
      px_q  <= req.pos_x;
      py_q  <= req.pos_y;
      ki_q  <= req.knot_index;
    end
    idx_q   <= idx_d;
    vec_q   <= vec_d;
    found_q <= found_d;
    stat_q  <= stat_d;
    ridx_q  <= ridx_d;
    map_q   <= map_d;
    y0_q    <= y0_d;
    dx_q    <= dx_d;
    ady_q   <= ady_d;
    ddx_q   <= ddx_d;
    neg_q   <= neg_d;
    if (out_load) begin
      o_stat_q <= stat_q;
      o_ridx_q <= ridx_q;
      o_map_q  <= map_q;
      o_cnt_q  <= count_q;
    end
  end

  assign rsp.valid        = rsp_vld_q;
  assign rsp.status       = o_stat_q;
  assign rsp.result_index = o_ridx_q;
  assign rsp.mapped_value = o_map_q;
  assign rsp.knot_total   = o_cnt_q;

endmodule

`default_nettype wire

@@ rtl/core/plct_checker.sv @@
`default_nettype none
`include "piecewise_linear_curve_table_macros.svh"

module plct_checker #(
  parameter  int unsigned MAX_KNOTS = plct_pkg::DEF_MAX_KNOTS,
  localparam int unsigned CNT_W     = $clog2(MAX_KNOTS + 1)
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       req_valid_i,
  input wire logic                       req_ready_i,
  input wire logic                       rsp_valid_i,
  input wire logic [2:0]                 rsp_status_i,
  input wire logic [plct_pkg::VAL_W-1:0] rsp_mapped_i,
  input wire logic [CNT_W-1:0]           rsp_total_i
);

  `PLCT_ASSERT_IMP(a_total_range, rsp_valid_i, rsp_total_i >= CNT_W'(2) && rsp_total_i <= CNT_W'(MAX_KNOTS), "knot total out of range")
  `PLCT_ASSERT_IMP(a_mapped_range, rsp_valid_i, rsp_mapped_i <= plct_pkg::Q_ONE, "mapped value above one")
  `PLCT_ASSERT_IMP(a_status_code, rsp_valid_i, rsp_status_i <= plct_pkg::STAT_ENDPOINT, "bad status code")
  `PLCT_ASSERT_NEXT(a_one_at_a_time, req_valid_i && req_ready_i, !req_ready_i, "request taken while busy")

endmodule

bind piecewise_linear_curve_table plct_checker #(
  .MAX_KNOTS (MAX_KNOTS)
) u_plct_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req.valid),
  .req_ready_i  (req.ready),
  .rsp_valid_i  (rsp.valid),
  .rsp_status_i (rsp.status),
  .rsp_mapped_i (rsp.mapped_value),
  .rsp_total_i  (rsp.knot_total)
);

`default_nettype wire

@@ dv/piecewise_linear_curve_table_test.sv @@
module piecewise_linear_curve_table_test;

  localparam int unsigned KNOTS = plct_pkg::DEF_MAX_KNOTS;
  localparam int unsigned WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  index;
    logic [16:0] mapped;
    logic [6:0]  total;
  } curve_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  plct_req_if req ();
  plct_rsp_if rsp ();
  plct_cfg_if cfg ();

  piecewise_linear_curve_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .rsp    (rsp),
    .cfg    (cfg)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // predicted table
  logic [16:0] curve_x [KNOTS];
  logic [16:0] curve_y [KNOTS];
  int unsigned curve_count;
  logic [16:0] radius;

  curve_result_t pending_results [$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit hold_off = 1'b0;

  function automatic logic [16:0] sat_one(logic [16:0] v);
    return (v > plct_pkg::Q_ONE) ? plct_pkg::Q_ONE : v;
  endfunction

  function automatic void curve_clear();
    curve_x[0] = '0;
    curve_y[0] = '0;
    curve_x[1] = plct_pkg::Q_ONE;
    curve_y[1] = plct_pkg::Q_ONE;
    curve_count = 2;
  endfunction

  function automatic curve_result_t apply_request(logic [2:0] kind, logic [16:0] px,
                                                  logic [16:0] py, logic [5:0] ki);
    curve_result_t r;
    int i;
    longint x0, y0, x1, y1, v, dx, dy, rr;
    r = '0;
    case (kind)
      plct_pkg::REQ_INSERT: begin
        if (px > plct_pkg::Q_ONE) begin
          r.status = plct_pkg::STAT_RANGE;
        end else begin
          py = sat_one(py);
          i = 0;
          while (i < curve_count && curve_x[i] < px) i++;
          if (i >= curve_count) begin
            r.status = plct_pkg::STAT_RANGE;
          end else if (curve_x[i] == px) begin
            curve_y[i] = py;
            r.index = 6'(i);
          end else if (curve_count >= KNOTS) begin
            r.status = plct_pkg::STAT_FULL;
          end else begin
            for (int j = curve_count; j > i; j--) begin
              curve_x[j] = curve_x[j-1];
              curve_y[j] = curve_y[j-1];
            end
            curve_x[i] = px;
            curve_y[i] = py;
            curve_count++;
            r.index = 6'(i);
          end
        end
      end
      plct_pkg::REQ_DELETE: begin
        if (ki >= curve_count) begin
          r.status = plct_pkg::STAT_RANGE;
        end else if (ki == 0 || ki == curve_count - 1) begin
          r.status = plct_pkg::STAT_ENDPOINT;
        end else begin
          for (int j = ki; j + 1 < curve_count; j++) begin
            curve_x[j] = curve_x[j+1];
            curve_y[j] = curve_y[j+1];
          end
          curve_count--;
          r.index = ki;
        end
      end
      plct_pkg::REQ_MOVE: begin
        if (ki >= curve_count) begin
          r.status = plct_pkg::STAT_RANGE;
        end else begin
          px = sat_one(px);
          py = sat_one(py);
          if (ki != 0 && ki != curve_count - 1) begin
            if (px < curve_x[ki-1]) px = curve_x[ki-1];
            if (px > curve_x[ki+1]) px = curve_x[ki+1];
            curve_x[ki] = px;
          end
          curve_y[ki] = py;
          r.index = ki;
        end
      end
      plct_pkg::REQ_FIND: begin
        rr = radius;
        r.status = plct_pkg::STAT_NOT_FOUND;
        for (i = 0; i < curve_count; i++) begin
          dx = longint'(px) - longint'(curve_x[i]);
          dy = longint'(py) - longint'(curve_y[i]);
          if (dx >= -rr && dx <= rr && dy >= -rr && dy <= rr) begin
            r.status = plct_pkg::STAT_OK;
            r.index = 6'(i);
            break;
          end
        end
      end
      plct_pkg::REQ_MAP: begin
        if (px > plct_pkg::Q_ONE) begin
          r.status = plct_pkg::STAT_RANGE;
        end else if (px == 0) begin
          r.mapped = curve_y[0];
        end else begin
          i = 1;
          while (i < curve_count && curve_x[i] < px) i++;
          if (i >= curve_count) begin
            r.status = plct_pkg::STAT_RANGE;
          end else begin
            x0 = curve_x[i-1];
            y0 = curve_y[i-1];
            x1 = curve_x[i];
            y1 = curve_y[i];
            if (x1 == x0) v = y1;
            else v = y0 + ((longint'(px) - x0) * (y1 - y0)) / (x1 - x0);
            if (v < 0) v = 0;
            if (v > plct_pkg::Q_ONE) v = plct_pkg::Q_ONE;
            r.mapped = v[16:0];
          end
        end
      end
      plct_pkg::REQ_RESET: curve_clear();
      default: r.status = plct_pkg::STAT_RANGE;
    endcase
    r.total = curve_count[6:0];
    return r;
  endfunction

  // sender: bursts with random gaps; valid drops only for a gap
  int unsigned burst_left = 0;

  task automatic send_request(logic [2:0] kind, logic [16:0] px, logic [16:0] py,
                              logic [5:0] ki);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.req_type <= kind;
    req.pos_x <= px;
    req.pos_y <= py;
    req.knot_index <= ki;
    do @(posedge clk_i); while (!req.ready);
    pending_results.push_back(apply_request(kind, px, py, ki));
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_radius(logic [16:0] value);
    drain();
    cfg.valid <= 1'b1;
    cfg.hit_radius <= value;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    radius = value;
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (hold_off) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 7) == 0);
  end

  always @(posedge clk_i) begin
    curve_result_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (rsp.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, rsp.status);
          errors++;
        end
        if (rsp.result_index !== want.index) begin
          $error("result_index exp %0d got %0d", want.index, rsp.result_index);
          errors++;
        end
        if (rsp.mapped_value !== want.mapped) begin
          $error("mapped_value exp %0d got %0d", want.mapped, rsp.mapped_value);
          errors++;
        end
        if (rsp.knot_total !== want.total) begin
          $error("knot_total exp %0d got %0d", want.total, rsp.knot_total);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [16:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return plct_pkg::Q_ONE;
      2: return 17'h1FFFF;
      3: return 17'($urandom_range(plct_pkg::Q_ONE + 1, 17'h1FFFF));
      default: return 17'($urandom_range(0, plct_pkg::Q_ONE));
    endcase
  endfunction

  task automatic test_directed();
    send_request(plct_pkg::REQ_MAP, 0, 0, 0);
    send_request(plct_pkg::REQ_MAP, plct_pkg::Q_ONE, 0, 0);
    send_request(plct_pkg::REQ_MAP, plct_pkg::Q_ONE + 1, 0, 0);
    send_request(plct_pkg::REQ_INSERT, 17'h1FFFF, 0, 0);
    send_request(plct_pkg::REQ_INSERT, 17'h08000, 17'h1FFFF, 0);
    send_request(plct_pkg::REQ_INSERT, 0, 17'h04000, 0);
    send_request(plct_pkg::REQ_INSERT, plct_pkg::Q_ONE, 17'h0C000, 0);
    send_request(plct_pkg::REQ_MAP, 17'h04000, 0, 0);
    send_request(plct_pkg::REQ_MAP, 17'h0C001, 0, 0);
    send_request(plct_pkg::REQ_DELETE, 0, 0, 0);
    send_request(plct_pkg::REQ_DELETE, 0, 0, 2);
    send_request(plct_pkg::REQ_DELETE, 0, 0, 6'h3F);
    send_request(plct_pkg::REQ_MOVE, 17'h1FFFF, 17'h1FFFF, 1);
    send_request(plct_pkg::REQ_MOVE, 17'h00010, 17'h1FFFF, 1);
    send_request(plct_pkg::REQ_MOVE, 17'h1FFFF, 0, 0);
    send_request(plct_pkg::REQ_MOVE, 0, 0, 2);
    send_request(plct_pkg::REQ_MOVE, 0, 0, 6'h3F);
    send_request(plct_pkg::REQ_FIND, 17'h00300, 17'h04100, 0);
    send_request(plct_pkg::REQ_FIND, 17'h1FFFF, 17'h1FFFF, 0);
    send_request(plct_pkg::REQ_DELETE, 0, 0, 1);
    send_request(3'd6, 17'h1FFFF, 17'h1FFFF, 6'h3F);
    send_request(3'd7, 0, 0, 0);
    send_request(plct_pkg::REQ_RESET, 0, 0, 0);
  endtask

  task automatic test_fill_table();
    for (int n = 0; n < 70; n++)
      send_request(plct_pkg::REQ_INSERT, 17'($urandom_range(1, plct_pkg::Q_ONE - 1)),
                   pick_coord(), 0);
    send_request(plct_pkg::REQ_MAP, 17'($urandom_range(1, plct_pkg::Q_ONE)), 0, 0);
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 12; n++)
        send_request(plct_pkg::REQ_FIND, pick_coord(), pick_coord(), 0);
    join
  endtask

  task automatic test_random(int unsigned count);
    logic [2:0] kind;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: kind = plct_pkg::REQ_INSERT;
        6, 7: kind = plct_pkg::REQ_DELETE;
        8, 9, 10: kind = plct_pkg::REQ_MOVE;
        11, 12, 13: kind = plct_pkg::REQ_FIND;
        14, 15, 16, 17: kind = plct_pkg::REQ_MAP;
        18: kind = ($urandom_range(0, 3) == 0) ? plct_pkg::REQ_RESET : plct_pkg::REQ_MAP;
        default: kind = 3'($urandom_range(6, 7));
      endcase
      send_request(kind, pick_coord(), pick_coord(),
                   ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, curve_count)));
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.req_type = '0;
    req.pos_x = '0;
    req.pos_y = '0;
    req.knot_index = '0;
    cfg.valid = 1'b0;
    cfg.hit_radius = '0;
    curve_clear();
    radius = plct_pkg::HIT_RADIUS_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_table();
    test_backpressure();
    test_random(300);
    write_radius(17'd0);
    test_random(150);
    write_radius(plct_pkg::Q_ONE);
    test_random(100);
    write_radius(17'h1FFFF);
    test_random(50);
    write_radius(17'($urandom_range(1, 8000)));
    test_random(200);
    drain();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
